@@ rtl/core/bgd_pkg.sv @@
// shared types and constants of the button gesture detector
package bgd_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned IDX_W = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_WINDOW   = 2'd2
    } t_reg_idx;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd80;
    localparam logic [CFG_W-1:0] HOLD_RST     = 16'd500;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd100;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] double_window_ms;
    } t_cfg;

    typedef struct packed {
        logic              pressed_flag;
        logic              release_pending;
        logic              second_press_flag;
        logic              hold_once_armed;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
    } t_state;

    typedef struct packed {
        logic press_event;
        logic double_event;
        logic hold_active;
        logic hold_first;
    } t_result;

endpackage

@@ rtl/core/bgd_if.sv @@
// channel interfaces: poll input, gesture result and register write
interface bgd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      button_level;
    logic [bgd_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bgd_out_if;
    logic valid;
    logic ready;
    logic press_event;
    logic double_event;
    logic hold_active;
    logic hold_first;

    modport source (output valid, output press_event, output double_event,
                     output hold_active, output hold_first, input ready);
    modport sink   (input valid, input press_event, input double_event,
                     input hold_active, input hold_first, output ready);
endinterface

interface bgd_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bgd_pkg::IDX_W-1:0] index;
    logic [bgd_pkg::CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/bgd_cfg.sv @@
// configuration register file for the three timing thresholds
module bgd_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr,
    input  logic [bgd_pkg::IDX_W-1:0] i_index,
    input  logic [bgd_pkg::CFG_W-1:0] i_data,
    output bgd_pkg::t_cfg             o_cfg
);

    bgd_pkg::t_cfg r_cfg;
    bgd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                bgd_pkg::REG_DEBOUNCE: n_cfg.debounce_ms      = i_data;
                bgd_pkg::REG_HOLD:     n_cfg.hold_ms          = i_data;
                bgd_pkg::REG_WINDOW:   n_cfg.double_window_ms = i_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= bgd_pkg::DEBOUNCE_RST;
            r_cfg.hold_ms          <= bgd_pkg::HOLD_RST;
            r_cfg.double_window_ms <= bgd_pkg::WINDOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/bgd_rules.sv @@
// one poll through the seven ordered gesture rules
module bgd_rules (
    input  bgd_pkg::t_cfg               i_cfg,
    input  bgd_pkg::t_state             i_state,
    input  logic                        i_level,
    input  logic [bgd_pkg::TIME_W-1:0]  i_now,
    output bgd_pkg::t_state             o_state,
    output bgd_pkg::t_result            o_result
);

    localparam int unsigned PAD_W = bgd_pkg::TIME_W - bgd_pkg::CFG_W;

    logic [bgd_pkg::TIME_W-1:0] w_debounce;
    logic [bgd_pkg::TIME_W-1:0] w_hold;
    logic [bgd_pkg::TIME_W-1:0] w_window;
    logic [bgd_pkg::TIME_W-1:0] w_dp0;
    logic [bgd_pkg::TIME_W-1:0] w_dr0;

    assign w_debounce = {{PAD_W{1'b0}}, i_cfg.debounce_ms};
    assign w_hold     = {{PAD_W{1'b0}}, i_cfg.hold_ms};
    assign w_window   = {{PAD_W{1'b0}}, i_cfg.double_window_ms};
    assign w_dp0      = i_now - i_state.press_stamp;
    assign w_dr0      = i_now - i_state.release_stamp;

    always_comb begin
        bgd_pkg::t_state            s;
        bgd_pkg::t_result           r;
        logic [bgd_pkg::TIME_W-1:0] dp;
        logic [bgd_pkg::TIME_W-1:0] dr;

        s  = i_state;
        r  = '0;
        dp = w_dp0;
        dr = w_dr0;

        // debounced press; restamping makes the press difference zero
        if (i_level && !s.pressed_flag && (dp > w_debounce)) begin
            s.pressed_flag    = 1'b1;
            s.hold_once_armed = 1'b1;
            s.press_stamp     = i_now;
            dp                = '0;
        end
        // short release
        if (!i_level && s.pressed_flag && !s.release_pending && !s.second_press_flag &&
            (dp < w_hold)) begin
            s.release_pending = 1'b1;
            s.pressed_flag    = 1'b0;
            s.release_stamp   = i_now;
            dr                = '0;
        end
        // single press once the double window has passed
        if (s.release_pending && !s.second_press_flag && (dr > w_window)) begin
            s.release_pending = 1'b0;
            r.press_event     = 1'b1;
        end
        // second press inside the window
        if (s.pressed_flag && !s.second_press_flag && s.release_pending &&
            (dr < w_window)) begin
            s.pressed_flag      = 1'b0;
            s.release_pending   = 1'b0;
            s.second_press_flag = 1'b1;
        end
        // double click
        if (s.second_press_flag && (dp < w_hold)) begin
            s.second_press_flag = 1'b0;
            r.double_event      = 1'b1;
            s.press_stamp       = i_now;
            dp                  = '0;
        end
        // hold
        if (s.pressed_flag && !r.double_event && !r.hold_active && (dp > w_hold)) begin
            r.hold_active = 1'b1;
        end
        // release after hold
        if (!i_level && s.pressed_flag && (dp > w_hold)) begin
            s.pressed_flag = 1'b0;
            r.hold_active  = 1'b0;
            s.press_stamp  = i_now;
        end
        if (r.hold_active && s.hold_once_armed) begin
            r.hold_first      = 1'b1;
            s.hold_once_armed = 1'b0;
        end

        o_state  = s;
        o_result = r;
    end

endmodule

@@ rtl/core/button_gesture_detector_top.sv @@
// top level of the button gesture detector
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    button_level, now_ms
//  o_out     out  valid/ready    press_event, double_event, hold_active, hold_first
//  i_cfg     in   valid/ready    index, data (always ready)
//
// each poll is latched in an input register, runs through the combinational rules and
// lands in the result register; one poll per cycle sustained while o_out is not stalled.
// the flag and stamp state is updated in the same cycle the result register loads.
// reset clears state and valids and loads the thresholds with 80, 500 and 100 ms.
// a stalled result holds the input register; a new poll is still taken while the
// result is taken in the same cycle.
module button_gesture_detector_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgd_in_if.sink     i_in,
    bgd_out_if.source  o_out,
    bgd_cfg_if.sink    i_cfg
);

    bgd_pkg::t_cfg    w_cfg;
    bgd_pkg::t_state  r_state;
    bgd_pkg::t_state  n_state;
    bgd_pkg::t_result r_result;
    bgd_pkg::t_result n_result;

    logic                       r_in_valid;
    logic                       r_level;
    logic [bgd_pkg::TIME_W-1:0] r_now;
    logic                       r_out_valid;
    logic                       w_adv;
    logic                       w_step;
    logic                       w_in_take;

    bgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    bgd_rules u_rules (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_level  (r_level),
        .i_now    (r_now),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign i_cfg.ready = 1'b1;

    assign w_adv     = !r_out_valid || o_out.ready;
    assign w_step    = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_level <= i_in.button_level;
            r_now   <= i_in.now_ms;
        end
        if (w_step) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.press_event  = r_result.press_event;
    assign o_out.double_event = r_result.double_event;
    assign o_out.hold_active  = r_result.hold_active;
    assign o_out.hold_first   = r_result.hold_first;

endmodule

@@ tb/bgd_gesture_monitor.sv @@
`timescale 1ns / 100ps
// gesture monitor: predicts the flags of every accepted poll and compares them with the block
module bgd_gesture_monitor
    import bgd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bgd_in_if    poll_mon,
    bgd_out_if   gest_mon,
    bgd_cfg_if   reg_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int REPORT_MAX = 10;

    t_cfg    thr;
    t_state  btn;
    t_result gestures_q[$];
    int      fail_cnt = 0;

    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] stamp);
        return now - stamp;
    endfunction

    // runs the seven rules in order on btn and returns this poll's flags
    function automatic t_result gesture_flags(input logic lvl, input logic [TIME_W-1:0] now);
        t_result r;
        r = '0;
        if (lvl && !btn.pressed_flag && elapsed(now, btn.press_stamp) > thr.debounce_ms) begin
            btn.pressed_flag    = 1'b1;
            btn.hold_once_armed = 1'b1;
            btn.press_stamp     = now;
        end
        if (!lvl && btn.pressed_flag && !btn.release_pending && !btn.second_press_flag &&
            elapsed(now, btn.press_stamp) < thr.hold_ms) begin
            btn.release_pending = 1'b1;
            btn.pressed_flag    = 1'b0;
            btn.release_stamp   = now;
        end
        if (btn.release_pending && !btn.second_press_flag &&
            elapsed(now, btn.release_stamp) > thr.double_window_ms) begin
            btn.release_pending = 1'b0;
            r.press_event       = 1'b1;
        end
        if (btn.pressed_flag && !btn.second_press_flag && btn.release_pending &&
            elapsed(now, btn.release_stamp) < thr.double_window_ms) begin
            btn.pressed_flag      = 1'b0;
            btn.release_pending   = 1'b0;
            btn.second_press_flag = 1'b1;
        end
        if (btn.second_press_flag && elapsed(now, btn.press_stamp) < thr.hold_ms) begin
            btn.second_press_flag = 1'b0;
            r.double_event        = 1'b1;
            btn.press_stamp       = now;
        end
        if (btn.pressed_flag && !r.double_event && !r.hold_active &&
            elapsed(now, btn.press_stamp) > thr.hold_ms) begin
            r.hold_active = 1'b1;
        end
        // release after a hold swallows the hold flag of this poll
        if (!lvl && btn.pressed_flag && elapsed(now, btn.press_stamp) > thr.hold_ms) begin
            btn.pressed_flag = 1'b0;
            r.hold_active    = 1'b0;
            btn.press_stamp  = now;
        end
        if (r.hold_active && btn.hold_once_armed) begin
            r.hold_first        = 1'b1;
            btn.hold_once_armed = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            thr.debounce_ms      = DEBOUNCE_RST;
            thr.hold_ms          = HOLD_RST;
            thr.double_window_ms = WINDOW_RST;
            btn                  = '0;
            gestures_q.delete();
        end else begin
            if (reg_mon.valid && reg_mon.ready) begin
                case (reg_mon.index)
                    REG_DEBOUNCE: thr.debounce_ms      = reg_mon.data;
                    REG_HOLD:     thr.hold_ms          = reg_mon.data;
                    REG_WINDOW:   thr.double_window_ms = reg_mon.data;
                    default: ;  // spare index, no register behind it
                endcase
            end
            // pop before push: a poll never comes out in the cycle it goes in
            if (gest_mon.valid && gest_mon.ready) begin
                if (gestures_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX) begin
                        $display("%0t: unexpected item: press=%0b double=%0b hold=%0b first=%0b",
                                 $realtime, gest_mon.press_event, gest_mon.double_event,
                                 gest_mon.hold_active, gest_mon.hold_first);
                    end
                end else begin
                    want = gestures_q.pop_front();
                    if (gest_mon.press_event  !== want.press_event  ||
                        gest_mon.double_event !== want.double_event ||
                        gest_mon.hold_active  !== want.hold_active  ||
                        gest_mon.hold_first   !== want.hold_first) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX) begin
                            // flags in order press, double, hold, first
                            $display("%0t: gesture mismatch: expected %4b, got %4b",
                                     $realtime, want,
                                     {gest_mon.press_event, gest_mon.double_event,
                                      gest_mon.hold_active, gest_mon.hold_first});
                        end
                    end
                end
            end
            if (poll_mon.valid && poll_mon.ready) begin
                gestures_q.push_back(gesture_flags(poll_mon.button_level, poll_mon.now_ms));
            end
        end
        o_pending <= gestures_q.size();
    end

    assign o_fail_count = fail_cnt;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, poll and threshold stimulus, and the final verdict
module tb_top;
    import bgd_pkg::*;

    localparam int RUN_LIMIT         = 300000;
    localparam int PHASE_POLLS       = 270;
    localparam int DRAIN_CYCLES      = 8;
    localparam int LONG_STALL_SEG    = 12;
    localparam int LONG_STALL_CYCLES = 400;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {GEST_CLICK, GEST_DOUBLE, GEST_HOLD, GEST_NOISE} t_gesture;
    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_COIN} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    int                cycle_cnt = 0;
    int                fail_count;
    int                pending;
    int                burst_left = 0;
    int                poll_count = 0;
    logic [TIME_W-1:0] poll_time = '0;
    int unsigned       deb_ms = DEBOUNCE_RST;
    int unsigned       hold_len = HOLD_RST;
    int unsigned       win_ms = WINDOW_RST;

    bgd_in_if  poll_ch();
    bgd_out_if gest_ch();
    bgd_cfg_if reg_ch();

    button_gesture_detector_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_ch),
        .o_out   (gest_ch),
        .i_cfg   (reg_ch)
    );

    bgd_gesture_monitor u_gesture_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .poll_mon     (poll_ch),
        .gest_mon     (gest_ch),
        .reg_mon      (reg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("[button_gesture_detector_top] ERROR");
            $finish;
        end
    end

    // a delay near a threshold: just below, equal, just above, around it, or zero, small or far above
    function automatic logic [TIME_W-1:0] step_near(input int unsigned th);
        case ($urandom_range(0, 7))
            0:       return (th == 0) ? '0 : th - 1;
            1:       return th;
            2:       return th + 1;
            3:       return $urandom_range(0, th / 2);
            4:       return $urandom_range(th, 2 * th + 2);
            5:       return '0;
            6:       return $urandom_range(1, 5);
            default: return th + $urandom_range(2, 2000);
        endcase
    endfunction

    // sender works in bursts with random gaps between them
    task automatic send_poll(input logic lvl, input logic [TIME_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                poll_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        poll_ch.valid        <= 1'b1;
        poll_ch.button_level <= lvl;
        poll_ch.now_ms       <= t;
        do @(posedge i_clk); while (!poll_ch.ready);
        poll_count++;
    endtask

    task automatic poll_after(input logic lvl, input logic [TIME_W-1:0] dt);
        poll_time = poll_time + dt;
        send_poll(lvl, poll_time);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
    endtask

    task automatic wait_drained();
        poll_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_thresholds(input int unsigned deb, input int unsigned hold,
                                  input int unsigned win);
        wait_drained();
        write_reg(REG_DEBOUNCE, CFG_W'(deb));
        write_reg(REG_HOLD, CFG_W'(hold));
        write_reg(REG_SPARE, CFG_W'($urandom));
        write_reg(REG_WINDOW, CFG_W'(win));
        reg_ch.valid <= 1'b0;
        deb_ms   = deb;
        hold_len = hold;
        win_ms   = win;
    endtask

    // mostly well formed clicks, double clicks and holds with random timing, some noise
    task automatic run_phase(input int n);
        int       stop_at;
        int       r;
        t_gesture kind;
        stop_at   = poll_count + n;
        poll_time = $urandom;
        while (poll_count < stop_at) begin
            r    = $urandom_range(0, 7);
            kind = (r < 2) ? GEST_CLICK : (r < 5) ? GEST_DOUBLE : (r < 7) ? GEST_HOLD : GEST_NOISE;
            case (kind)
                GEST_CLICK: begin
                    poll_after(1'b0, $urandom_range(0, 20));
                    poll_after(1'b1, step_near(deb_ms));
                    repeat ($urandom_range(0, 2)) poll_after(1'b1, $urandom_range(0, hold_len / 4));
                    poll_after(1'b0, ($urandom_range(0, 3) == 0) ? step_near(hold_len)
                                                                  : $urandom_range(0, hold_len / 2));
                    repeat ($urandom_range(1, 3)) poll_after(1'b0, step_near(win_ms));
                end
                GEST_DOUBLE: begin
                    poll_after(1'b1, step_near(deb_ms));
                    poll_after(1'b0, $urandom_range(0, hold_len / 2));
                    poll_after(1'b1, ($urandom_range(0, 1) == 0) ? $urandom_range(0, win_ms)
                                                                  : step_near(win_ms));
                    repeat ($urandom_range(0, 2)) poll_after(1'b1, $urandom_range(0, hold_len / 2));
                    poll_after(1'b0, step_near(hold_len / 2));
                    repeat ($urandom_range(1, 2)) poll_after(1'b0, step_near(win_ms));
                end
                GEST_HOLD: begin
                    poll_after(1'b1, step_near(deb_ms));
                    repeat ($urandom_range(2, 6)) poll_after(1'b1, step_near(hold_len / 3));
                    poll_after(1'b0, step_near(hold_len));
                    poll_after(1'b0, step_near(win_ms));
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 3))
                            0:       poll_after(1'($urandom_range(0, 1)), $urandom);
                            // time running backwards
                            1:       poll_after(1'($urandom_range(0, 1)),
                                                32'(0 - $urandom_range(0, 300)));
                            default: poll_after(1'($urandom_range(0, 1)), $urandom_range(0, 3));
                        endcase
                    end
                end
            endcase
        end
    endtask

    // receiver stalls on a pattern of its own, with one long hold-off
    initial begin
        int       seg;
        int       seg_len;
        t_rx_mode mode;
        gest_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        seg = 0;
        forever begin
            seg++;
            if (seg == LONG_STALL_SEG) begin
                gest_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            end else begin
                mode    = t_rx_mode'($urandom_range(0, 3));
                seg_len = $urandom_range(5, 60);
                repeat (seg_len) begin
                    case (mode)
                        RX_ALWAYS: gest_ch.ready <= 1'b1;
                        RX_MOSTLY: gest_ch.ready <= ($urandom_range(0, 3) != 0);
                        RX_SPARSE: gest_ch.ready <= ($urandom_range(0, 3) == 0);
                        default:   gest_ch.ready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        poll_ch.valid        <= 1'b0;
        poll_ch.button_level <= 1'b0;
        poll_ch.now_ms       <= '0;
        reg_ch.valid         <= 1'b0;
        reg_ch.index         <= '0;
        reg_ch.data          <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // thresholds at reset values: 80 / 500 / 100
        send_poll(1'b1, 32'd40);           // press too close to time zero
        send_poll(1'b1, 32'd80);           // exactly at debounce
        send_poll(1'b1, 32'd81);
        send_poll(1'b0, 32'd181);          // short release
        send_poll(1'b0, 32'd281);          // exactly at window
        send_poll(1'b0, 32'd282);          // single press
        send_poll(1'b1, 32'd400);
        send_poll(1'b0, 32'd450);
        send_poll(1'b1, 32'd520);          // second press inside window
        send_poll(1'b0, 32'd530);
        send_poll(1'b1, 32'd700);
        send_poll(1'b1, 32'd1200);         // exactly at hold time
        send_poll(1'b1, 32'd1201);         // first hold poll
        send_poll(1'b1, 32'd1300);
        send_poll(1'b0, 32'd1400);         // release after hold
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'h0000_0010);    // release across the wrap
        send_poll(1'b0, 32'h0000_000F);    // time steps back
        send_poll(1'b1, 32'h0000_0000);
        send_poll(1'b0, 32'h0000_0000);

        run_phase(PHASE_POLLS);
        set_thresholds(0, 0, 0);
        run_phase(PHASE_POLLS);
        set_thresholds(65535, 65535, 65535);
        run_phase(PHASE_POLLS);
        set_thresholds($urandom_range(0, 200), $urandom_range(0, 1000), $urandom_range(0, 300));
        run_phase(PHASE_POLLS);
        set_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
        run_phase(PHASE_POLLS);
        set_thresholds(DEBOUNCE_RST, HOLD_RST, WINDOW_RST);
        run_phase(PHASE_POLLS);

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("[button_gesture_detector_top] OK");
        end else begin
            $display("[button_gesture_detector_top] ERROR");
        end
        $finish;
    end

endmodule
